### rtl/header_length_checksum_frame_checker_core_assert.svh
// assertion macros for the frame checker
// each macro checks on the rising edge of the clock given and is held off during reset
`ifndef HEADER_LENGTH_CHECKSUM_FRAME_CHECKER_CORE_ASSERT_SVH
`define HEADER_LENGTH_CHECKSUM_FRAME_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property holds at every edge outside reset
`define HLCFC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("frame checker assertion failed");

// consequent holds in the cycle after the antecedent
`define HLCFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`else

`define HLCFC_ASSERT(lbl, clk, rst, prop)

`define HLCFC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/hlcfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hlcfc_pkg;

  // header byte and smallest legal length
  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] LEN_MIN     = 8'd2;
  // length byte plus two header bytes ahead of the summed bytes
  localparam int unsigned FRAME_OVERHEAD = 3;

  // verdict codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNREG   = 3'd1;
  localparam logic [2:0] ST_BAD_HDR = 3'd2;
  localparam logic [2:0] ST_BAD_CHK = 3'd3;
  localparam logic [2:0] ST_BAD_LEN = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_LIMIT = 2'd0;
  localparam logic [1:0] CFG_IDX_MASK  = 2'd1;

  localparam int unsigned CFG_WIDTH   = 64;
  localparam int unsigned LIMIT_WIDTH = 7;

  // parser phase; idle also covers the time after a verdict
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR2,
    PH_LEN,
    PH_CMD,
    PH_BODY,
    PH_CHK
  } phase_t;

  // one received byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } byte_t;

  // one verdict
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] command_id;
  } verdict_t;

  // per-frame parser state
  typedef struct packed {
    phase_t     phase;
    logic [7:0] bytes_left;
    logic [7:0] running_sum;
    logic [7:0] held_command;
  } frame_state_t;

endpackage

`default_nettype wire

### rtl/hlcfc_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module hlcfc_parse #(
  parameter int unsigned MAX_FRAME_BYTES = 32
) (
  input  hlcfc_pkg::frame_state_t               state,
  input  hlcfc_pkg::byte_t                      item,
  input  logic [hlcfc_pkg::LIMIT_WIDTH-1:0]     cmd_limit,
  input  logic [hlcfc_pkg::CFG_WIDTH-1:0]       cmd_mask,
  output hlcfc_pkg::frame_state_t               state_next,
  output logic                                  emit,
  output hlcfc_pkg::verdict_t                   verdict
);

  // largest length byte whose checksum still lies inside the record
  localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME_BYTES - hlcfc_pkg::FRAME_OVERHEAD);

  hlcfc_pkg::phase_t phase_next;
  logic              is_header;
  logic              len_bad;
  logic [7:0]        left_dec;
  logic [7:0]        sum_add;
  logic              chk_bad;
  logic              cmd_known;

  // per-byte decode
  assign is_header = (item.data_byte == hlcfc_pkg::HEADER_BYTE);
  assign len_bad   = (item.data_byte < hlcfc_pkg::LEN_MIN) || (item.data_byte > LEN_MAX);
  assign left_dec  = state.bytes_left - 8'd1;
  assign sum_add   = state.running_sum + item.data_byte;
  assign chk_bad   = (~state.running_sum != item.data_byte);
  assign cmd_known = ({1'b0, cmd_limit} > state.held_command) &&
                     (state.held_command[7:6] == 2'b00) &&
                     cmd_mask[state.held_command[5:0]];

  // next phase
  always_comb begin
    phase_next = state.phase;
    if (item.first) begin
      phase_next = is_header ? hlcfc_pkg::PH_HDR2 : hlcfc_pkg::PH_IDLE;
    end else begin
      case (state.phase)
        hlcfc_pkg::PH_HDR2: phase_next = is_header ? hlcfc_pkg::PH_LEN : hlcfc_pkg::PH_IDLE;
        hlcfc_pkg::PH_LEN:  phase_next = len_bad ? hlcfc_pkg::PH_IDLE : hlcfc_pkg::PH_CMD;
        hlcfc_pkg::PH_CMD,
        hlcfc_pkg::PH_BODY: begin
          phase_next = (left_dec == 8'd0) ? hlcfc_pkg::PH_CHK : hlcfc_pkg::PH_BODY;
        end
        hlcfc_pkg::PH_CHK:  phase_next = hlcfc_pkg::PH_IDLE;
        default:            phase_next = hlcfc_pkg::PH_IDLE;
      endcase
    end
  end

  // counters, sum, held command and verdict
  always_comb begin
    state_next         = state;
    state_next.phase   = phase_next;
    emit               = 1'b0;
    verdict.status     = hlcfc_pkg::ST_OK;
    verdict.command_id = 8'd0;
    if (item.first) begin
      state_next.bytes_left   = 8'd0;
      state_next.running_sum  = 8'd0;
      state_next.held_command = 8'd0;
      if (!is_header) begin
        emit           = 1'b1;
        verdict.status = hlcfc_pkg::ST_BAD_HDR;
      end
    end else begin
      case (state.phase)
        hlcfc_pkg::PH_HDR2: begin
          if (!is_header) begin
            emit           = 1'b1;
            verdict.status = hlcfc_pkg::ST_BAD_HDR;
          end
        end
        hlcfc_pkg::PH_LEN: begin
          if (len_bad) begin
            emit           = 1'b1;
            verdict.status = hlcfc_pkg::ST_BAD_LEN;
          end else begin
            state_next.bytes_left  = item.data_byte - 8'd1;
            state_next.running_sum = 8'd0;
          end
        end
        hlcfc_pkg::PH_CMD: begin
          state_next.held_command = item.data_byte;
          state_next.running_sum  = sum_add;
          state_next.bytes_left   = left_dec;
        end
        hlcfc_pkg::PH_BODY: begin
          state_next.running_sum = sum_add;
          state_next.bytes_left  = left_dec;
        end
        hlcfc_pkg::PH_CHK: begin
          emit               = 1'b1;
          verdict.command_id = state.held_command;
          if (chk_bad) begin
            verdict.status = hlcfc_pkg::ST_BAD_CHK;
          end else if (!cmd_known) begin
            verdict.status = hlcfc_pkg::ST_UNREG;
          end else begin
            verdict.status = hlcfc_pkg::ST_OK;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/header_length_checksum_frame_checker_core.sv
// Frame checker for header / length / checksum framed command records.
// Byte channel: byte_valid, byte_stall, byte_data {data_byte, first}; a transfer
// happens at a clock edge with valid high and stall low. first marks the
// opening byte of each record.
// Verdict channel: verdict_valid, verdict_stall, verdict_data {status, command_id};
// at most one verdict per record, on the byte that decides it.
// Config: cfg_write, cfg_index, cfg_value; index 0 is the command limit,
// index 1 the command enable mask. Write only while no record is in flight.
// A byte taken passes through the input register and then the verdict register.
// Throughput: one byte per cycle while the verdict register is not stalled; each byte is one
// pass of the parser step between the input register and the verdict register.
// Stall: while the verdict register is full and stalled the parser holds,
// the input register keeps its byte and byte_stall rises once it is full.
// Reset (rst, synchronous): parser goes idle, both registers empty,
// configuration cleared to zero.
`timescale 1ns / 1ps
`default_nettype none

module header_length_checksum_frame_checker_core #(
  parameter int unsigned MAX_FRAME_BYTES = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  hlcfc_pkg::byte_t                   byte_data,
  output logic                               verdict_valid,
  input  logic                               verdict_stall,
  output hlcfc_pkg::verdict_t                verdict_data,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [hlcfc_pkg::CFG_WIDTH-1:0]    cfg_value
);

  `include "header_length_checksum_frame_checker_core_assert.svh"

  // input register
  logic                    held_valid;
  hlcfc_pkg::byte_t        held_byte;
  // parser state and configuration
  hlcfc_pkg::frame_state_t state;
  hlcfc_pkg::frame_state_t state_next;
  logic [hlcfc_pkg::LIMIT_WIDTH-1:0] cmd_limit;
  logic [hlcfc_pkg::CFG_WIDTH-1:0]   cmd_mask;
  // step results
  logic                    emit;
  hlcfc_pkg::verdict_t     verdict;
  logic                    fire;
  logic                    byte_take;

  // handshake
  assign fire       = held_valid && !(verdict_valid && verdict_stall);
  assign byte_stall = held_valid && !fire;
  assign byte_take  = byte_valid && !byte_stall;

  // parser step
  hlcfc_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .state      (state),
    .item       (held_byte),
    .cmd_limit  (cmd_limit),
    .cmd_mask   (cmd_mask),
    .state_next (state_next),
    .emit       (emit),
    .verdict    (verdict)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_take) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
    if (byte_take) begin
      held_byte <= byte_data;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= hlcfc_pkg::PH_IDLE;
      state.bytes_left   <= 8'd0;
      state.running_sum  <= 8'd0;
      state.held_command <= 8'd0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_limit <= '0;
      cmd_mask  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        hlcfc_pkg::CFG_IDX_LIMIT: cmd_limit <= cfg_value[hlcfc_pkg::LIMIT_WIDTH-1:0];
        hlcfc_pkg::CFG_IDX_MASK:  cmd_mask  <= cfg_value;
        default: begin
          cmd_limit <= cmd_limit;
        end
      endcase
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (fire && emit) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
    if (fire && emit) begin
      verdict_data <= verdict;
    end
  end

  // checks
  `HLCFC_ASSERT(a_stall_when_blocked, clk, rst, (held_valid && verdict_valid && verdict_stall) |-> byte_stall)
  `HLCFC_ASSERT(a_status_legal, clk, rst, verdict_valid |-> (verdict_data.status <= hlcfc_pkg::ST_BAD_LEN))
  `HLCFC_ASSERT(a_no_cmd_on_early_fail, clk, rst, (verdict_valid && (verdict_data.status == hlcfc_pkg::ST_BAD_HDR || verdict_data.status == hlcfc_pkg::ST_BAD_LEN)) |-> (verdict_data.command_id == 8'd0))
  `HLCFC_ASSERT(a_chk_count_done, clk, rst, (state.phase == hlcfc_pkg::PH_CHK) |-> (state.bytes_left == 8'd0))
  `HLCFC_ASSERT_NEXT(a_first_header_opens, clk, rst, fire && held_byte.first && (held_byte.data_byte == hlcfc_pkg::HEADER_BYTE), state.phase == hlcfc_pkg::PH_HDR2)

endmodule

`default_nettype wire

### bench/header_length_checksum_frame_checker_core_tb.sv
`timescale 1ns / 1ps

module header_length_checksum_frame_checker_core_tb;
  import hlcfc_pkg::*;

  localparam int unsigned MAX_FRAME_BYTES = 32;
  // longest length byte whose checksum still fits in the record
  localparam int unsigned LONGEST_LEN = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  // indexes past the last register, which the block must ignore
  localparam logic [1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_IDX_SPARE_B = 2'd3;

  // one line of the directed script
  typedef struct packed {
    logic       cfg;        // rewrite the registers instead of sending a byte
    logic       typed;      // verdict given here rather than predicted
    logic [7:0] data;
    logic       first;
    logic [2:0] status;
    logic [7:0] command_id;
  } script_row_t;

  localparam script_row_t WIDEN_REGS = {1'b1, 1'b0, 8'h00, 1'b0, ST_OK, 8'h00};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_stall;
  byte_t                byte_data = '0;
  logic                 verdict_valid;
  logic                 verdict_stall = 1'b0;
  verdict_t             verdict_data;
  logic                 cfg_write = 1'b0;
  logic [1:0]           cfg_index = CFG_IDX_LIMIT;
  logic [CFG_WIDTH-1:0] cfg_value = '0;

  // frame tracker state and its copy of the registers
  phase_t                 frame_phase = PH_IDLE;
  logic [7:0]             frame_left = '0;
  logic [7:0]             frame_sum = '0;
  logic [7:0]             frame_cmd = '0;
  logic [LIMIT_WIDTH-1:0] reg_limit = '0;
  logic [CFG_WIDTH-1:0]   reg_mask = '0;
  verdict_t               expected_verdicts [$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;

  int bytes_used = 0;
  int verdicts_seen = 0;
  int accepted_seen = 0;
  int unreg_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;

  header_length_checksum_frame_checker_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .verdict_valid(verdict_valid),
    .verdict_stall(verdict_stall),
    .verdict_data (verdict_data),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_value    (cfg_value)
  );

  always #2 clk = ~clk;

  // record a verdict and drop back to idle until the next first byte
  function automatic void queue_verdict(input logic [2:0] st, input logic [7:0] id);
    verdict_t v;
    v.status = st;
    v.command_id = id;
    expected_verdicts.push_back(v);
    frame_phase = PH_IDLE;
  endfunction

  // advance the frame tracker by one transferred byte
  function automatic void track_byte(input logic [7:0] d, input logic f);
    if (f) begin
      frame_left = '0;
      frame_sum = '0;
      frame_cmd = '0;
      bytes_used++;
      if (d != HEADER_BYTE) queue_verdict(ST_BAD_HDR, 8'h00);
      else frame_phase = PH_HDR2;
    end else begin
      if (frame_phase != PH_IDLE) bytes_used++;
      case (frame_phase)
        PH_HDR2: begin
          if (d != HEADER_BYTE) queue_verdict(ST_BAD_HDR, 8'h00);
          else frame_phase = PH_LEN;
        end
        PH_LEN: begin
          if (d < LEN_MIN || int'(d) + FRAME_OVERHEAD > MAX_FRAME_BYTES) begin
            queue_verdict(ST_BAD_LEN, 8'h00);
          end else begin
            frame_left = d - 8'd1;
            frame_sum = '0;
            frame_phase = PH_CMD;
          end
        end
        PH_CMD, PH_BODY: begin
          if (frame_phase == PH_CMD) frame_cmd = d;
          frame_sum = frame_sum + d;
          frame_left = frame_left - 8'd1;
          frame_phase = (frame_left == 8'd0) ? PH_CHK : PH_BODY;
        end
        PH_CHK: begin
          if (~frame_sum != d) begin
            queue_verdict(ST_BAD_CHK, frame_cmd);
          end else if (frame_cmd < reg_limit && int'(frame_cmd) < CFG_WIDTH &&
                       reg_mask[frame_cmd[5:0]]) begin
            queue_verdict(ST_OK, frame_cmd);
          end else begin
            queue_verdict(ST_UNREG, frame_cmd);
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic script_row_t raw_byte(input logic [7:0] d, input logic f);
    script_row_t r;
    r = '0;
    r.data = d;
    r.first = f;
    return r;
  endfunction

  function automatic script_row_t verdict_byte(input logic [7:0] d, input logic f,
                                               input logic [2:0] st, input logic [7:0] id);
    script_row_t r;
    r = raw_byte(d, f);
    r.typed = 1'b1;
    r.status = st;
    r.command_id = id;
    return r;
  endfunction

  // offer one byte, idling first at random, and hold it until its transfer
  task automatic put_byte(input logic [7:0] d, input logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= {d, f};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    track_byte(d, f);
  endtask

  // stop sending and wait for every outstanding verdict
  task automatic settle();
    byte_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves the write enable high; the caller lowers it
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_value <= v;
    @(posedge clk);
    if (idx == CFG_IDX_LIMIT) reg_limit = v[LIMIT_WIDTH-1:0];
    else if (idx == CFG_IDX_MASK) reg_mask = v;
  endtask

  task automatic configure(input logic [CFG_WIDTH-1:0] limit_word,
                           input logic [CFG_WIDTH-1:0] mask_word);
    write_reg(CFG_IDX_LIMIT, limit_word);
    write_reg(CFG_IDX_MASK, mask_word);
    write_reg(CFG_IDX_SPARE_A, {$urandom, $urandom});
    write_reg(CFG_IDX_SPARE_B, {$urandom, $urandom});
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // random records until count more bytes have been used
  task automatic run_frames(input int count);
    int goal;
    int pick;
    int len;
    int keep;
    logic [7:0] b;
    logic [7:0] sum;
    byte_t frame_q [$];
    goal = bytes_used + count;
    while (bytes_used < goal) begin
      frame_q.delete();
      pick = $urandom_range(99);
      if (pick < 6) begin
        // header broken on the first or the second byte
        if ($urandom_range(1) == 0) begin
          frame_q.push_back({8'($urandom_range(254)), 1'b1});
        end else begin
          frame_q.push_back({HEADER_BYTE, 1'b1});
          frame_q.push_back({8'($urandom_range(254)), 1'b0});
        end
      end else if (pick < 12) begin
        // length too short or reaching past the record
        frame_q.push_back({HEADER_BYTE, 1'b1});
        frame_q.push_back({HEADER_BYTE, 1'b0});
        if ($urandom_range(2) == 0) b = 8'($urandom_range(1));
        else b = 8'($urandom_range(255, LONGEST_LEN + 1));
        frame_q.push_back({b, 1'b0});
      end else begin
        // well-formed record, mostly short, checksum now and then wrong
        len = ($urandom_range(7) == 0) ? $urandom_range(LONGEST_LEN, 2) : $urandom_range(6, 2);
        b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(63));
        frame_q.push_back({HEADER_BYTE, 1'b1});
        frame_q.push_back({HEADER_BYTE, 1'b0});
        frame_q.push_back({8'(len), 1'b0});
        frame_q.push_back({b, 1'b0});
        sum = b;
        repeat (len - 2) begin
          b = 8'($urandom);
          frame_q.push_back({b, 1'b0});
          sum = sum + b;
        end
        b = ~sum;
        if ($urandom_range(7) == 0) b = b ^ 8'($urandom_range(255, 1));
        frame_q.push_back({b, 1'b0});
        // cut short, so the next first byte abandons it
        if (pick >= 90) begin
          keep = $urandom_range(frame_q.size() - 1, 1);
          while (frame_q.size() > keep) void'(frame_q.pop_back());
        end
      end
      // stray bytes behind the record
      if ($urandom_range(11) == 0) begin
        repeat ($urandom_range(3, 1)) frame_q.push_back({8'($urandom), 1'b0});
      end
      foreach (frame_q[i]) put_byte(frame_q[i].data_byte, frame_q[i].first);
    end
    // a lone bad first byte closes any record left open
    put_byte(8'($urandom_range(254)), 1'b1);
  endtask

  // verdict side: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      verdict_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      verdict_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      verdict_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare each verdict transfer with the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdict_valid && !verdict_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("verdict with none expected: status %0d command_id 0x%02h",
               verdict_data.status, verdict_data.command_id);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, verdict_data.status);
          fail_count++;
        end
        if (verdict_data.command_id !== want.command_id) begin
          $error("command_id: expected 0x%02h, got 0x%02h",
                 want.command_id, verdict_data.command_id);
          fail_count++;
        end
        verdicts_seen++;
        if (want.status == ST_OK) accepted_seen++;
        else if (want.status == ST_UNREG) unreg_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run timed out after %0d cycles, %0d verdicts outstanding",
             cycle_count, expected_verdicts.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    script_row_t script [$];
    verdict_t typed;
    script = '{
      // well-formed record under reset registers: limit zero refuses it
      raw_byte(HEADER_BYTE, 1'b1), raw_byte(HEADER_BYTE, 1'b0), raw_byte(8'h02, 1'b0),
      raw_byte(8'h00, 1'b0), verdict_byte(8'hFF, 1'b0, ST_UNREG, 8'h00),
      // first byte not a header byte
      verdict_byte(8'h00, 1'b1, ST_BAD_HDR, 8'h00),
      // stray byte after a verdict
      raw_byte(8'h55, 1'b0),
      // second header byte wrong
      raw_byte(HEADER_BYTE, 1'b1), verdict_byte(8'hFE, 1'b0, ST_BAD_HDR, 8'h00),
      // length below two
      raw_byte(HEADER_BYTE, 1'b1), raw_byte(HEADER_BYTE, 1'b0),
      verdict_byte(8'h01, 1'b0, ST_BAD_LEN, 8'h00),
      // checksum one off
      raw_byte(HEADER_BYTE, 1'b1), raw_byte(HEADER_BYTE, 1'b0), raw_byte(8'h02, 1'b0),
      raw_byte(8'hFF, 1'b0), verdict_byte(8'h01, 1'b0, ST_BAD_CHK, 8'hFF),
      // widest register settings
      WIDEN_REGS,
      // accepted command
      raw_byte(HEADER_BYTE, 1'b1), raw_byte(HEADER_BYTE, 1'b0), raw_byte(8'h02, 1'b0),
      raw_byte(8'h3F, 1'b0), raw_byte(8'hC0, 1'b0),
      // record cut after its header, then a command id beyond the mask
      raw_byte(HEADER_BYTE, 1'b1), raw_byte(HEADER_BYTE, 1'b0),
      raw_byte(HEADER_BYTE, 1'b1), raw_byte(HEADER_BYTE, 1'b0), raw_byte(8'h02, 1'b0),
      raw_byte(8'h80, 1'b0), raw_byte(8'h7F, 1'b0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed script
    foreach (script[i]) begin
      if (script[i].cfg) begin
        settle();
        configure('1, '1);
      end else begin
        put_byte(script[i].data, script[i].first);
        if (script[i].typed) begin
          typed.status = script[i].status;
          typed.command_id = script[i].command_id;
          void'(expected_verdicts.pop_back());
          expected_verdicts.push_back(typed);
        end
      end
    end
    settle();

    // sender busy, receiver mostly stalled
    configure(64'd64, {$urandom, $urandom});
    send_idle_pct = 6;
    recv_stall_pct = 79;
    run_frames(380);
    settle();

    // sender mostly idle, with a full drain half way
    configure({$urandom, $urandom}, {$urandom, $urandom});
    send_idle_pct = 79;
    recv_stall_pct = 6;
    run_frames(190);
    settle();
    configure({$urandom, $urandom} & ~64'h7F, 64'd0);
    run_frames(190);
    settle();

    // no idling, one long hold-off so the block backs up into its input
    configure(64'd64, '1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    run_frames(390);
    settle();

    $display("frame checker: %0d bytes used, %0d verdicts checked (%0d accepted, %0d unregistered)",
             bytes_used, verdicts_seen, accepted_seen, unreg_seen);
    $display("covered header, length and checksum faults, cut-off records, stray bytes, "
             , "stalls on both sides and a long verdict hold-off");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
